### src/pwc_pkg.sv
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared types and constants for the pulse watering controller.
// ----------------------------------------------------------------------------
package pwc_pkg;

	localparam int unsigned MS_PER_MINUTE = 60 * 1000;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RELAY_ON        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSES      = 3'd4;

	// configuration reset values
	localparam logic [31:0] RST_SAMPLE_INTERVAL = 32'(30 * MS_PER_MINUTE);
	localparam logic [6:0]  RST_THRESHOLD       = 7'd40;
	localparam logic [31:0] RST_RELAY_ON        = 32'd5000;
	localparam logic [31:0] RST_SETTLE          = 32'd30000;
	localparam logic [7:0]  RST_MAX_PULSES      = 8'd5;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ON     = 2'd1,
		PH_SETTLE = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_OK    = 3'd1,
		EV_START = 3'd2,
		EV_OFF   = 3'd3,
		EV_DONE  = 3'd4,
		EV_LIMIT = 3'd5,
		EV_NEXT  = 3'd6
	} event_t;

	typedef struct packed {
		logic [31:0] sample_interval_ms;
		logic [6:0]  moisture_threshold;
		logic [31:0] relay_on_ms;
		logic [31:0] settle_ms;
		logic [7:0]  max_pulses;
	} cfg_t;

	typedef struct packed {
		logic              relay_on;
		logic [1:0]        phase;
		logic [2:0]        event_res;
		logic signed [7:0] last_reading;
		logic [7:0]        pulses_done;
	} result_t;

endpackage

### src/pulse_watering_controller_top.sv
// ----------------------------------------------------------------------------
// pulse_watering_controller_top
// Pulse watering controller: one request per millisecond tick, one result
// per request.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid/in_ready carries moisture_pct, one request per tick
//   output channel out_valid/out_ready carries relay_on, phase, event_res,
//     last_reading and pulses_done after that tick
//   config channel cfg_valid/cfg_ready writes cfg_data to register cfg_index
//     (0 sample interval, 1 threshold, 2 relay on time, 3 settle time,
//     4 max pulses); cfg_ready is always high, write only while idle
// Pipeline: a request goes to an input register, then through the phase
//   update into the result register, from which its result is offered on
//   the output channel.
// Throughput: one request per cycle while out_ready is high; the phase
//   update and the counter compares fit between the input and result registers.
// Reset: phase idle, relay off, pulse count zero, last reading -1, elapsed
//   counters zero, registers to their defaults; both pipeline slots empty.
// Stall: while out_ready is low the result holds; the input register still
//   takes one more request, then in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module pulse_watering_controller_top #(
	parameter int TIMER_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [6:0]                    moisture_pct,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          relay_on,
	output logic [1:0]                    phase,
	output logic [2:0]                    event_res,
	output logic signed [7:0]             last_reading,
	output logic [7:0]                    pulses_done,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import pwc_pkg::*;

	cfg_t       cfg;
	result_t    res;
	result_t    res_s2;
	logic       valid_s1, valid_s2;
	logic [6:0] moisture_s1;
	logic       adv;
	logic       step;

	assign cfg_ready = 1'b1;

	pwc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// pipeline advance control
	assign adv      = !valid_s2 || out_ready;
	assign step     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) moisture_s1 <= moisture_pct;
	end

	pwc_core #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.moisture (moisture_s1),
		.cfg      (cfg),
		.res      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) res_s2 <= res;
	end

	assign out_valid    = valid_s2;
	assign relay_on     = res_s2.relay_on;
	assign phase        = res_s2.phase;
	assign event_res    = res_s2.event_res;
	assign last_reading = res_s2.last_reading;
	assign pulses_done  = res_s2.pulses_done;

	// relay drive matches the pump-on phase
	a_relay_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (relay_on == (phase == PH_ON)))
		else $error("relay drive disagrees with phase");

	// a new watering run starts with a cleared pulse count
	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == EV_START) |-> (pulses_done == 8'd0))
		else $error("pulse count not cleared at watering start");

	// relay off always moves to settling
	a_off_settle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res == EV_OFF) |-> (phase == PH_SETTLE && !relay_on))
		else $error("relay off without settling");

	// an empty result register never blocks new requests
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

endmodule

### src/pwc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pwc_cfg_regs
// Configuration register file, written one register per request.
// ----------------------------------------------------------------------------
module pwc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [pwc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [31:0]                   wr_data,
	output pwc_pkg::cfg_t                 cfg
);
	import pwc_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_interval_ms <= RST_SAMPLE_INTERVAL;
			cfg_q.moisture_threshold <= RST_THRESHOLD;
			cfg_q.relay_on_ms        <= RST_RELAY_ON;
			cfg_q.settle_ms          <= RST_SETTLE;
			cfg_q.max_pulses         <= RST_MAX_PULSES;
		end else if (wr_en) begin
			case (wr_index)
				CFG_SAMPLE_INTERVAL: cfg_q.sample_interval_ms <= wr_data;
				CFG_THRESHOLD:       cfg_q.moisture_threshold <= wr_data[6:0];
				CFG_RELAY_ON:        cfg_q.relay_on_ms        <= wr_data;
				CFG_SETTLE:          cfg_q.settle_ms          <= wr_data;
				CFG_MAX_PULSES:      cfg_q.max_pulses         <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/pwc_core.sv
// ----------------------------------------------------------------------------
// pwc_core
// Controller state and the per-tick phase update.
// ----------------------------------------------------------------------------
module pwc_core #(
	parameter int TIMER_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [6:0]       moisture,
	input  pwc_pkg::cfg_t    cfg,
	output pwc_pkg::result_t res
);
	import pwc_pkg::*;

	localparam int CW = (TIMER_WIDTH > 32) ? TIMER_WIDTH : 32;

	phase_t                 phase_q, phase_d;
	logic [7:0]             pulses_q, pulses_d;
	logic signed [7:0]      last_q, last_d;
	logic [TIMER_WIDTH-1:0] since_rd_q, since_rd_d, since_rd_inc;
	logic [TIMER_WIDTH-1:0] since_rl_q, since_rl_d, since_rl_inc;
	logic                   relay_q, relay_d;
	event_t                 ev;
	logic                   rd_due, on_due, settle_due;
	logic                   below;

	// saturating elapsed counters
	assign since_rd_inc = (&since_rd_q) ? since_rd_q : since_rd_q + 1'b1;
	assign since_rl_inc = (&since_rl_q) ? since_rl_q : since_rl_q + 1'b1;

	// interval compares at the wider of the two widths
	assign rd_due     = CW'(since_rd_inc) >= CW'(cfg.sample_interval_ms);
	assign on_due     = CW'(since_rl_inc) >= CW'(cfg.relay_on_ms);
	assign settle_due = CW'(since_rl_inc) >= CW'(cfg.settle_ms);
	assign below      = moisture < cfg.moisture_threshold;

	// phase update for one tick
	always_comb begin
		phase_d    = phase_q;
		pulses_d   = pulses_q;
		last_d     = last_q;
		since_rd_d = since_rd_inc;
		since_rl_d = since_rl_inc;
		relay_d    = relay_q;
		ev         = EV_NONE;
		case (phase_q)
			PH_ON: begin
				if (on_due) begin
					relay_d    = 1'b0;
					since_rl_d = '0;
					if (pulses_q != 8'hFF) pulses_d = pulses_q + 8'd1;
					phase_d    = PH_SETTLE;
					ev         = EV_OFF;
				end
			end
			PH_SETTLE: begin
				if (settle_due) begin
					last_d     = {1'b0, moisture};
					since_rd_d = '0;
					if (!below) begin
						phase_d = PH_IDLE;
						ev      = EV_DONE;
					end else if (pulses_q >= cfg.max_pulses) begin
						phase_d = PH_IDLE;
						ev      = EV_LIMIT;
					end else begin
						relay_d    = 1'b1;
						since_rl_d = '0;
						phase_d    = PH_ON;
						ev         = EV_NEXT;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (rd_due) begin
					last_d     = {1'b0, moisture};
					since_rd_d = '0;
					if (below) begin
						pulses_d   = '0;
						relay_d    = 1'b1;
						since_rl_d = '0;
						phase_d    = PH_ON;
						ev         = EV_START;
					end else begin
						ev = EV_OK;
					end
				end
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pulses_q   <= '0;
			last_q     <= -8'sd1;
			since_rd_q <= '0;
			since_rl_q <= '0;
			relay_q    <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			pulses_q   <= pulses_d;
			last_q     <= last_d;
			since_rd_q <= since_rd_d;
			since_rl_q <= since_rl_d;
			relay_q    <= relay_d;
		end
	end

	// result of this tick
	assign res.relay_on     = relay_d;
	assign res.phase        = phase_d;
	assign res.event_res    = ev;
	assign res.last_reading = last_d;
	assign res.pulses_done  = pulses_d;

endmodule

### tb/tb_pulse_watering_controller_top.sv
// ----------------------------------------------------------------------------
// tb_pulse_watering_controller_top
// Drives millisecond tick requests with moisture readings into the pulse
// watering controller and checks every result against a cycle-free model of
// the idle / pump on / settle sequence, over several register settings.
// ----------------------------------------------------------------------------
module tb_pulse_watering_controller_top;

	import pwc_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [6:0]           moisture_pct;
	logic                 out_valid;
	logic                 out_ready;
	logic                 relay_on;
	logic [1:0]           phase;
	logic [2:0]           event_res;
	logic signed [7:0]    last_reading;
	logic [7:0]           pulses_done;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	// watering model state and its copy of the registers
	cfg_t              water_cfg;
	phase_t            mdl_phase;
	logic [7:0]        mdl_pulses;
	logic signed [7:0] mdl_reading;
	logic [31:0]       mdl_since_read;
	logic [31:0]       mdl_since_relay;
	logic              mdl_relay;

	result_t expected_results[$];
	int      fail_count;

	// sender burst control and receiver stall control
	int burst_left;
	bit gaps_on;
	int hold_request;
	int hold_left;
	int rx_mode;
	int mode_left;

	pulse_watering_controller_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.moisture_pct (moisture_pct),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.relay_on     (relay_on),
		.phase        (phase),
		.event_res    (event_res),
		.last_reading (last_reading),
		.pulses_done  (pulses_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// one tick of the watering sequence
	task automatic predict_watering_tick(input logic [6:0] m, output result_t r);
		event_t ev;
		ev = EV_NONE;
		// elapsed counters saturate before the phase compares
		if (mdl_since_read != '1)
			mdl_since_read++;
		if (mdl_since_relay != '1)
			mdl_since_relay++;
		case (mdl_phase)
			PH_ON: begin
				if (mdl_since_relay >= water_cfg.relay_on_ms) begin
					mdl_relay = 1'b0;
					mdl_since_relay = '0;
					if (mdl_pulses != 8'hFF)
						mdl_pulses++;
					mdl_phase = PH_SETTLE;
					ev = EV_OFF;
				end
			end
			PH_SETTLE: begin
				if (mdl_since_relay >= water_cfg.settle_ms) begin
					mdl_reading = $signed({1'b0, m});
					mdl_since_read = '0;
					if (m >= water_cfg.moisture_threshold) begin
						mdl_phase = PH_IDLE;
						ev = EV_DONE;
					end else if (mdl_pulses >= water_cfg.max_pulses) begin
						mdl_phase = PH_IDLE;
						ev = EV_LIMIT;
					end else begin
						mdl_relay = 1'b1;
						mdl_since_relay = '0;
						mdl_phase = PH_ON;
						ev = EV_NEXT;
					end
				end
			end
			default: begin
				mdl_phase = PH_IDLE;
				if (mdl_since_read >= water_cfg.sample_interval_ms) begin
					mdl_reading = $signed({1'b0, m});
					mdl_since_read = '0;
					if (m < water_cfg.moisture_threshold) begin
						mdl_pulses = '0;
						mdl_relay = 1'b1;
						mdl_since_relay = '0;
						mdl_phase = PH_ON;
						ev = EV_START;
					end else begin
						ev = EV_OK;
					end
				end
			end
		endcase
		r.relay_on     = mdl_relay;
		r.phase        = mdl_phase;
		r.event_res    = ev;
		r.last_reading = mdl_reading;
		r.pulses_done  = mdl_pulses;
	endtask

	// result check, then prediction and register tracking
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no request pending");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (relay_on !== want.relay_on) begin
						$error("relay_on: expected %0d, actual %0d", want.relay_on, relay_on);
						fail_count++;
					end
					if (phase !== want.phase) begin
						$error("phase: expected %0d, actual %0d", want.phase, phase);
						fail_count++;
					end
					if (event_res !== want.event_res) begin
						$error("event_res: expected %0d, actual %0d", want.event_res, event_res);
						fail_count++;
					end
					if (last_reading !== want.last_reading) begin
						$error("last_reading: expected %0d, actual %0d",
							want.last_reading, last_reading);
						fail_count++;
					end
					if (pulses_done !== want.pulses_done) begin
						$error("pulses_done: expected %0d, actual %0d",
							want.pulses_done, pulses_done);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_watering_tick(moisture_pct, want);
				expected_results.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SAMPLE_INTERVAL: water_cfg.sample_interval_ms = cfg_data;
					CFG_THRESHOLD:       water_cfg.moisture_threshold = cfg_data[6:0];
					CFG_RELAY_ON:        water_cfg.relay_on_ms        = cfg_data;
					CFG_SETTLE:          water_cfg.settle_ms          = cfg_data;
					CFG_MAX_PULSES:      water_cfg.max_pulses         = cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	// receiver: random stall modes, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			if (mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(8, 80);
			end
			mode_left--;
			case (rx_mode)
				0: out_ready = 1'b1;
				1: out_ready = ($urandom_range(0, 3) != 0);
				2: out_ready = ($urandom_range(0, 9) < 3);
				default: out_ready = ~out_ready;
			endcase
		end
	end

	// one tick request, with random gaps between bursts
	task automatic send_tick(input logic [6:0] m);
		if (gaps_on && burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 30);
		end
		moisture_pct = m;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_registers(input logic [31:0] interval, input logic [6:0] thr,
			input logic [31:0] on_ms, input logic [31:0] settle, input logic [7:0] max_p);
		write_register(CFG_SAMPLE_INTERVAL, interval);
		write_register(CFG_THRESHOLD, {25'd0, thr});
		write_register(CFG_RELAY_ON, on_ms);
		write_register(CFG_SETTLE, settle);
		write_register(CFG_MAX_PULSES, {24'd0, max_p});
	endtask

	// stop offering and wait for every pending result
	task automatic wait_results_drained;
		in_valid = 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	// default registers: the long sample interval keeps the block quiet
	task automatic test_reset_defaults;
		repeat (5) send_tick(7'($urandom_range(0, 127)));
		wait_results_drained();
	endtask

	// short durations walk through every event
	task automatic test_directed_sequence;
		logic [6:0] seq [25] = '{127, 0, 100, 39, 40, 10, 10, 10, 10, 10, 10, 10, 10,
			10, 10, 64, 50, 0, 0, 0, 0, 0, 0, 0, 41};
		set_registers(32'd2, 7'd40, 32'd1, 32'd1, 8'd2);
		foreach (seq[i])
			send_tick(seq[i]);
		wait_results_drained();
	endtask

	// a limit of zero gives up after the first pulse
	task automatic test_limit_of_zero;
		set_registers(32'd0, 7'd50, 32'd0, 32'd0, 8'd0);
		repeat (10) send_tick(7'($urandom_range(0, 49)));
		send_tick(7'd127);
		send_tick(7'd0);
		wait_results_drained();
	endtask

	// dry soil and the widest limit run the pulse count up to its top
	task automatic test_pulse_count_saturation;
		set_registers(32'd0, 7'd127, 32'd0, 32'd0, 8'd255);
		repeat (540) send_tick(7'($urandom_range(0, 126)));
		wait_results_drained();
	endtask

	// all-ones durations never elapse, zero threshold never waters
	task automatic test_extreme_durations;
		set_registers(32'hFFFF_FFFF, 7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255);
		repeat (6) send_tick(7'($urandom_range(0, 127)));
		wait_results_drained();
		write_register(CFG_SAMPLE_INTERVAL, 32'd0);
		repeat (6) send_tick(7'($urandom_range(0, 127)));
		wait_results_drained();
		write_register(CFG_THRESHOLD, 32'd100);
		send_tick(7'd0);
		repeat (7) send_tick(7'($urandom_range(0, 127)));
		wait_results_drained();
	endtask

	// random registers, moisture mostly close to the threshold
	task automatic test_random_settings;
		logic [6:0] thr;
		int         lo;
		int         hi;
		for (int s = 0; s < 6; s++) begin
			thr = 7'($urandom_range(0, 101));
			set_registers(32'($urandom_range(0, 40)), thr, 32'($urandom_range(0, 12)),
				32'($urandom_range(0, 12)),
				8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 6)));
			lo = (thr < 8) ? 0 : thr - 8;
			hi = (thr > 119) ? 127 : thr + 8;
			// two settings run back to back, one of them against a long receiver hold-off
			gaps_on = (s != 2 && s != 4);
			if (s == 2)
				hold_request = 400;
			repeat (220) begin
				if ($urandom_range(0, 4) != 0)
					send_tick(7'($urandom_range(lo, hi)));
				else
					send_tick(7'($urandom_range(0, 127)));
			end
			wait_results_drained();
		end
		gaps_on = 1'b1;
	endtask

	// sequence of tests
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		moisture_pct = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		hold_request = 0;
		hold_left = 0;
		rx_mode = 0;
		mode_left = 0;
		water_cfg.sample_interval_ms = RST_SAMPLE_INTERVAL;
		water_cfg.moisture_threshold = RST_THRESHOLD;
		water_cfg.relay_on_ms = RST_RELAY_ON;
		water_cfg.settle_ms = RST_SETTLE;
		water_cfg.max_pulses = RST_MAX_PULSES;
		mdl_phase = PH_IDLE;
		mdl_pulses = '0;
		mdl_reading = -8'sd1;
		mdl_since_read = '0;
		mdl_since_relay = '0;
		mdl_relay = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_directed_sequence();
		test_limit_of_zero();
		test_pulse_count_saturation();
		test_extreme_durations();
		test_random_settings();

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// run limit
	initial begin
		#8000000;
		$display("Verification failed");
		$finish;
	end

endmodule
